// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the following edge.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ebpc_pkg.sv
// ----------------------------------------------------------------------------
// ebpc_pkg
// Types and constants of the encoder and button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ebpc_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int TIME_BITS   = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int EV_W        = 3;

    // level vector bit positions
    localparam int LV_CLK    = 0;
    localparam int LV_DATA   = 1;
    localparam int LV_BTN0   = 2;
    localparam int LEVELS_W  = LV_BTN0 + NUM_BUTTONS;

    localparam int S_FIELDS_W = TIME_BITS + LEVELS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 + EV_W * NUM_BUTTONS;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd2;

    localparam logic [CFG_W-1:0] GLITCH_RST = 16'd5;
    localparam logic [CFG_W-1:0] CLICK_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] HOLD_RST   = 16'd2000;

    typedef enum logic [EV_W-1:0] {
        EV_NONE  = 3'd0,
        EV_PRESS = 3'd1,
        EV_CLICK = 3'd2,
        EV_SHORT = 3'd3,
        EV_LONG  = 3'd4
    } event_t;

    typedef struct packed {
        logic [CFG_W-1:0] glitch_ms;
        logic [CFG_W-1:0] click_limit_ms;
        logic [CFG_W-1:0] hold_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic                   turn_left;
        logic                   turn_right;
        logic [NUM_BUTTONS-1:0] btn_changed;
    } step_info_t;

endpackage

`default_nettype wire

// File: rtl/core/ebpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ebpc_cfg_regs
// Threshold registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ebpc_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ebpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ebpc_pkg::CFG_W-1:0]    cfg_wdata,
    output ebpc_pkg::cfg_t                     cfg
);

    ebpc_pkg::cfg_t cfg_reg;
    ebpc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ebpc_pkg::CFG_GLITCH: cfg_next.glitch_ms      = cfg_wdata;
                ebpc_pkg::CFG_CLICK:  cfg_next.click_limit_ms = cfg_wdata;
                ebpc_pkg::CFG_HOLD:   cfg_next.hold_limit_ms  = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.glitch_ms      <= ebpc_pkg::GLITCH_RST;
            cfg_reg.click_limit_ms <= ebpc_pkg::CLICK_RST;
            cfg_reg.hold_limit_ms  <= ebpc_pkg::HOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/ebpc_sample_track.sv
// ----------------------------------------------------------------------------
// ebpc_sample_track
// Keeps the previous pin levels and the primed flag; detects the encoder
// step and the switch level changes of the current sample.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ebpc_sample_track (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic [ebpc_pkg::LEVELS_W-1:0] levels,
    output ebpc_pkg::step_info_t               info
);

    logic [ebpc_pkg::LEVELS_W-1:0] prev_levels_reg;
    logic                          primed_reg;
    logic [ebpc_pkg::LEVELS_W-1:0] changed;

    assign changed = levels ^ prev_levels_reg;

    always_comb begin
        info.turn_left   = 1'b0;
        info.turn_right  = 1'b0;
        info.btn_changed = '0;
        if (primed_reg) begin
            if (changed[ebpc_pkg::LV_CLK] && levels[ebpc_pkg::LV_CLK]) begin
                if (levels[ebpc_pkg::LV_CLK] != levels[ebpc_pkg::LV_DATA]) begin
                    info.turn_left = 1'b1;
                end else begin
                    info.turn_right = 1'b1;
                end
            end
            info.btn_changed = changed[ebpc_pkg::LV_BTN0 +: ebpc_pkg::NUM_BUTTONS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_levels_reg <= '0;
            primed_reg      <= 1'b0;
        end else if (step) begin
            prev_levels_reg <= levels;
            primed_reg      <= 1'b1;
        end
    end

    `ASSERT_NEXT(a_primes_on_first, aclk, aresetn, step, primed_reg,
        "primed flag not set after a sample")
    `ASSERT_ALWAYS(a_unprimed_quiet, aclk, aresetn,
        primed_reg || (!info.turn_left && !info.turn_right && info.btn_changed == '0),
        "event reported on the priming sample")

endmodule

`default_nettype wire

// File: rtl/core/ebpc_button.sv
// ----------------------------------------------------------------------------
// ebpc_button
// One switch: pressed flag, press timestamp and release duration classifier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ebpc_button (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic                           changed,
    input  wire logic                           level,
    input  wire logic [ebpc_pkg::TIME_BITS-1:0] now_ms,
    input  wire ebpc_pkg::cfg_t                 cfg,
    output ebpc_pkg::event_t                    ev
);

    logic                           down_reg;
    logic                           down_next;
    logic [ebpc_pkg::TIME_BITS-1:0] press_time_reg;
    logic [ebpc_pkg::TIME_BITS-1:0] press_time_next;
    logic [ebpc_pkg::TIME_BITS-1:0] elapsed;

    // wraps modulo 2^TIME_BITS
    assign elapsed = now_ms - press_time_reg;

    always_comb begin
        ev              = ebpc_pkg::EV_NONE;
        down_next       = down_reg;
        press_time_next = press_time_reg;
        if (changed && (down_reg != level)) begin
            down_next = level;
            if (level) begin
                press_time_next = now_ms;
                ev              = ebpc_pkg::EV_PRESS;
            end else begin
                priority if (elapsed < ebpc_pkg::TIME_BITS'(cfg.glitch_ms)) begin
                    ev = ebpc_pkg::EV_NONE;
                end else if (elapsed < ebpc_pkg::TIME_BITS'(cfg.click_limit_ms)) begin
                    ev = ebpc_pkg::EV_CLICK;
                end else if (elapsed < ebpc_pkg::TIME_BITS'(cfg.hold_limit_ms)) begin
                    ev = ebpc_pkg::EV_SHORT;
                end else begin
                    ev = ebpc_pkg::EV_LONG;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg <= 1'b0;
        end else if (step) begin
            down_reg <= down_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            press_time_reg <= press_time_next;
        end
    end

    `ASSERT_NEXT(a_press_sets_down, aclk, aresetn,
        step && ev == ebpc_pkg::EV_PRESS, down_reg,
        "switch not marked down after press")
    `ASSERT_NEXT(a_release_clears_down, aclk, aresetn,
        step && (ev == ebpc_pkg::EV_CLICK || ev == ebpc_pkg::EV_SHORT
                 || ev == ebpc_pkg::EV_LONG),
        !down_reg, "switch still marked down after release")

endmodule

`default_nettype wire

// File: rtl/core/encoder_and_button_press_classifier_top.sv
// ----------------------------------------------------------------------------
// encoder_and_button_press_classifier_top
// Rotary encoder step decoder and per-switch press duration classifier.
//
//   Channel  Dir  Bits        Contents (lowest bit first)
//   s_       in   tdata 40    now_ms[31:0], enc_clock, enc_data, button0..2
//   m_       out  tdata 16    turn_left, turn_right, button0..2_event[2:0]
//   cfg_     in   wdata 16    0 glitch_ms, 1 click_limit_ms, 2 hold_limit_ms
//
// One sample per cycle sustained while m_tready holds high: input register,
// one subtract and three compares per switch, result register. Each sample
// is held in the input register, then in the result register. Synchronous
// active-low reset; the first sample after reset only primes the stored
// levels and yields an all-zero result. A stalled result holds the output
// register; the input register still takes one more sample behind it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module encoder_and_button_press_classifier_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // now_ms[31:0], enc_clock[32], enc_data[33], button0[34], button1[35],
    // button2[36], zero fill
    input  wire logic [ebpc_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // turn_left[0], turn_right[1], button0_event[4:2], button1_event[7:5],
    // button2_event[10:8], zero fill
    output      logic [ebpc_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ebpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ebpc_pkg::CFG_W-1:0]     cfg_wdata
);

    ebpc_pkg::cfg_t       cfg;
    ebpc_pkg::step_info_t info;
    ebpc_pkg::event_t     ev [ebpc_pkg::NUM_BUTTONS];

    logic                           in_vld_reg;
    logic [ebpc_pkg::TIME_BITS-1:0] in_now_reg;
    logic [ebpc_pkg::LEVELS_W-1:0]  in_levels_reg;
    logic                           out_vld_reg;
    logic [ebpc_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [ebpc_pkg::M_TDATA_W-1:0] out_data_next;
    logic                           out_free;
    logic                           step;

    assign out_free = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    ebpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ebpc_sample_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .levels  (in_levels_reg),
        .info    (info)
    );

    for (genvar i = 0; i < ebpc_pkg::NUM_BUTTONS; i++) begin : g_btn
        ebpc_button u_btn (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (step),
            .changed (info.btn_changed[i]),
            .level   (in_levels_reg[ebpc_pkg::LV_BTN0 + i]),
            .now_ms  (in_now_reg),
            .cfg     (cfg),
            .ev      (ev[i])
        );
    end

    always_comb begin
        out_data_next    = '0;
        out_data_next[0] = info.turn_left;
        out_data_next[1] = info.turn_right;
        for (int i = 0; i < ebpc_pkg::NUM_BUTTONS; i++) begin
            out_data_next[2 + ebpc_pkg::EV_W * i +: ebpc_pkg::EV_W] = ev[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (out_free) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_now_reg    <= s_tdata[ebpc_pkg::TIME_BITS-1:0];
            in_levels_reg <= s_tdata[ebpc_pkg::TIME_BITS +: ebpc_pkg::LEVELS_W];
        end
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_vld_reg;

    `ASSERT_NEXT(a_step_fills_output, aclk, aresetn, step, m_tvalid,
        "result register empty after a transfer into it")
    `ASSERT_ALWAYS(a_one_direction, aclk, aresetn,
        !(m_tvalid && m_tdata[0] && m_tdata[1]),
        "encoder reported left and right together")

endmodule

`default_nettype wire
